// ===== rtl/fwdf_pkg.sv =====
// Shared types and constants of the fixed-width decimal formatter.
`timescale 1ns / 1ps

package fwdf_pkg;

  // Input word and its decimal expansion.
  localparam int VALUE_W   = 32;
  localparam int DIGITS    = 10;
  localparam int BCD_W     = 4 * DIGITS;
  localparam int DIG_IDX_W = $clog2(DIGITS);

  // Field geometry.
  localparam int RESULT_CAP    = 16;
  localparam int MAX_WIDTH_DEF = 16;
  localparam int FW_W          = 5;
  localparam int DEC_W         = 4;
  localparam int POS_W         = 4;

  // Queue between front and back; keep it a power of two.
  localparam int Q_DEPTH = 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMALS    = 2'd1;

  localparam logic [FW_W-1:0]  FIELD_WIDTH_RST = 5'd8;
  localparam logic [DEC_W-1:0] DECIMALS_RST    = 4'd0;

  // Characters.
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Effective field settings, already clamped.
  typedef struct packed {
    logic [FW_W-1:0]  width;
    logic [DEC_W-1:0] decimals;
  } cfg_t;

  // One classified item, ready for emission.
  typedef struct packed {
    logic [DIGITS-1:0][3:0] digits;
    logic                   neg;
    logic                   hashes;
    logic [FW_W-1:0]        width;
    logic [DEC_W-1:0]       decimals;
    logic [FW_W-1:0]        dotpos;
  } rec_t;

endpackage

// ===== rtl/fwdf_front.sv =====
// Front end: accept a value, convert it to BCD two bits a cycle, classify the field.
`timescale 1ns / 1ps

module fwdf_front
  import fwdf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [VALUE_W-1:0] value_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output rec_t               push_data_o
);

  localparam int STEPS = VALUE_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic               busy_q, done_q, neg_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [VALUE_W-1:0] mag_q;
  logic [BCD_W-1:0]   bcd_q;

  logic               fin, accept;
  logic [VALUE_W-1:0] mag_in;

  // One shift-and-add-3 step.
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] b,
                                               input logic bit_in);
    logic [BCD_W-1:0] r;
    r = b;
    for (int i = 0; i < DIGITS; i++) begin
      if (r[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = r[4*i +: 4] + 4'd3;
      end
    end
    return {r[BCD_W-2:0], bit_in};
  endfunction

  assign mag_in = value_i[VALUE_W-1] ? (VALUE_W'(0) - value_i) : value_i;

  // A zero-width field produces nothing: drop the item instead of pushing it.
  assign push_valid_o = done_q && (cfg_i.width != '0);
  assign fin          = done_q && ((cfg_i.width == '0) || push_ready_i);
  assign in_ready_o   = !busy_q || fin;
  assign accept       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= CNT_W'(1);
      end else if (fin) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
      end else if (busy_q && !done_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // The first step runs in the accept cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q <= value_i[VALUE_W-1];
      mag_q <= {mag_in[VALUE_W-3:0], 2'b00};
      bcd_q <= dd_step(dd_step('0, mag_in[VALUE_W-1]), mag_in[VALUE_W-2]);
    end else if (busy_q && !done_q) begin
      mag_q <= {mag_q[VALUE_W-3:0], 2'b00};
      bcd_q <= dd_step(dd_step(bcd_q, mag_q[VALUE_W-1]), mag_q[VALUE_W-2]);
    end
  end

  // Fit check on the finished digits.
  logic [DEC_W-1:0] n_digits, widest;
  logic [FW_W-1:0]  need;
  logic             hashes;

  always_comb begin
    n_digits = DEC_W'(1);
    for (int i = 1; i < DIGITS; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        n_digits = DEC_W'(i + 1);
      end
    end
    widest = (n_digits > cfg_i.decimals) ? n_digits : cfg_i.decimals;
    need   = FW_W'(neg_q) + FW_W'(widest) + FW_W'(cfg_i.decimals != '0);
    hashes = (FW_W'(cfg_i.decimals) >= cfg_i.width) || (need > cfg_i.width);

    push_data_o.digits   = bcd_q;
    push_data_o.neg      = neg_q;
    push_data_o.hashes   = hashes;
    push_data_o.width    = cfg_i.width;
    push_data_o.decimals = cfg_i.decimals;
    push_data_o.dotpos   = (cfg_i.decimals != '0 && !hashes)
                         ? (cfg_i.width - FW_W'(cfg_i.decimals) - FW_W'(1))
                         : cfg_i.width;
  end

endmodule

// ===== rtl/fwdf_fifo.sv =====
// Short queue of classified items between front and back.
`timescale 1ns / 1ps

module fwdf_fifo
  import fwdf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  rec_t  push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output rec_t  pop_data_o
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  rec_t             mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(Q_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/fwdf_back.sv =====
// Back end: walk one field left to right and emit a character per transfer.
`timescale 1ns / 1ps

module fwdf_back
  import fwdf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  rec_t             pop_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       text_char_o,
  output logic [POS_W-1:0] position_o,
  output logic             overflow_o,
  output logic             last_o
);

  rec_t             rec_q;
  logic             have_q, out_valid_q;
  logic [POS_W-1:0] pos_q;
  logic [7:0]       char_q;
  logic [POS_W-1:0] opos_q;
  logic             ovf_q, last_q;

  logic             adv, load, is_last, pop;
  logic [FW_W-1:0]  pos_ext, k;
  logic [3:0]       digit;
  logic [7:0]       ch;

  assign adv     = !out_valid_q || out_ready_i;
  assign load    = have_q && adv;
  assign pos_ext = FW_W'(pos_q);
  assign is_last = (pos_ext == rec_q.width - FW_W'(1));
  assign pop     = pop_valid_i && (!have_q || (load && is_last));
  assign pop_ready_o = !have_q || (load && is_last);

  always_comb begin
    k = (rec_q.decimals != '0 && pos_ext < rec_q.dotpos)
      ? (rec_q.width - FW_W'(2) - pos_ext)
      : (rec_q.width - FW_W'(1) - pos_ext);
    digit = (k < FW_W'(DIGITS)) ? rec_q.digits[k[DIG_IDX_W-1:0]] : 4'd0;
    if (rec_q.hashes) begin
      ch = CH_HASH;
    end else if (rec_q.decimals != '0 && pos_ext == rec_q.dotpos) begin
      ch = CH_POINT;
    end else if (rec_q.neg && pos_q == '0) begin
      ch = CH_MINUS;
    end else begin
      ch = CH_ZERO + {4'b0000, digit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        have_q <= 1'b1;
        pos_q  <= '0;
      end else if (load) begin
        pos_q <= pos_q + POS_W'(1);
        if (is_last) have_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) rec_q <= pop_data_i;
    if (load) begin
      char_q <= ch;
      opos_q <= pos_q;
      ovf_q  <= rec_q.hashes;
      last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign position_o  = opos_q;
  assign overflow_o  = ovf_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/fixed_width_decimal_formatter.sv =====
// Top level of the fixed-width decimal formatter: config registers, front, queue, back.
//
// Usage: each transfer on the input channel (value_i) is a signed 32-bit integer.
// The block answers with field_width characters on the output channel, one per
// transfer, left to right: right-aligned, zero-padded, optional '.', leading '-',
// or all '#' with overflow_o set when the number does not fit. last_o marks the
// rightmost character. Widths above the MAX_WIDTH / 16 limit are clamped; a width
// of zero yields no output at all.
// Configuration: cfg_index_i selects field_width (0) or decimals (1); other
// indexes are ignored. cfg_ready_o is always high. Write only while idle.
// Path: the value is converted into the BCD register, then passes the queue and the
// back end's field register into the output register. Throughput: the front end's
// binary to BCD converter retires two bits per cycle; the back end emits one
// character per cycle while out_ready_i is high. A two-entry queue lets them overlap.
// Stalls: a stalled receiver holds the current character in the output register; the
// queue then fills, and in_ready_o is low until the front end can pass its value on.
// Reset: asynchronous, active low; clears the queue and pipeline, field_width = 8,
// decimals = 0.
`timescale 1ns / 1ps

module fixed_width_decimal_formatter
  import fwdf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FW_W-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [VALUE_W-1:0]   value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           text_char_o,
  output logic [POS_W-1:0]     position_o,
  output logic                 overflow_o,
  output logic                 last_o
);

  // Largest field the block will emit.
  localparam int LIM = (MAX_WIDTH < RESULT_CAP) ? MAX_WIDTH : RESULT_CAP;

  logic [FW_W-1:0]  field_width_q;
  logic [DEC_W-1:0] decimals_q;
  cfg_t             cfg;

  logic push_valid, push_ready, pop_valid, pop_ready;
  rec_t push_data, pop_data;

  // Config writes always complete; cfg_ready_o is tied high.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_width_q <= FIELD_WIDTH_RST;
      decimals_q    <= DECIMALS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FIELD_WIDTH: field_width_q <= cfg_data_i;
        REG_DECIMALS:    decimals_q    <= cfg_data_i[DEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the width once so both ends see the same field.
  assign cfg.width    = (field_width_q > FW_W'(LIM)) ? FW_W'(LIM) : field_width_q;
  assign cfg.decimals = decimals_q;

  // Front end: accept, convert, classify.
  fwdf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decouple conversion from emission.
  fwdf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back end: character walk and output register.
  fwdf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .text_char_o (text_char_o),
    .position_o  (position_o),
    .overflow_o  (overflow_o),
    .last_o      (last_o)
  );

  // A field of hashes carries nothing else.
  a_hash_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> text_char_o == CH_HASH)
    else $error("overflow character is not a hash");

  // Inside a field the next character follows at once, one position on.
  a_next_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      out_valid_o && position_o == POS_W'($past(position_o) + POS_W'(1)))
    else $error("field character missing or out of order");

  // Overflow holds for the whole field.
  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> overflow_o == $past(overflow_o))
    else $error("overflow changed inside a field");

endmodule
